### rtl/sih_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sih_pkg: shared types and constants for the setup initiator handshake
// Transaction payload structs, event and action codes, register map and
// register reset values.
// ----------------------------------------------------------------------------
package sih_pkg;

	localparam int unsigned APB_ADDR_W = 5;
	localparam int unsigned APB_DATA_W = 64;
	localparam int unsigned TIME_W     = 64;
	localparam int unsigned HASH_W     = 64;
	localparam int unsigned RETRY_W    = 8;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_TIMEOUT  = 2'd0;
	localparam reg_idx_t REG_RETRY    = 2'd1;
	localparam reg_idx_t REG_OWN_HASH = 2'd2;

	localparam logic [TIME_W-1:0]  TIMEOUT_RST  = 64'd1000000000;
	localparam logic [RETRY_W-1:0] RETRY_RST    = 8'd5;
	localparam logic [HASH_W-1:0]  OWN_HASH_RST = 64'd0;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_START = 2'd0;
	localparam kind_t KIND_DGRAM = 2'd1;
	localparam kind_t KIND_TIMER = 2'd2;

	typedef logic [1:0] action_t;
	localparam action_t ACT_NONE = 2'd0;
	localparam action_t ACT_DATA = 2'd1;
	localparam action_t ACT_FIN  = 2'd2;

	typedef logic [1:0] status_t;
	localparam status_t ST_NOT_SENT = 2'd0;
	localparam status_t ST_WAITING  = 2'd1;
	localparam status_t ST_MATCHED  = 2'd2;
	localparam status_t ST_FAILED   = 2'd3;

	typedef struct packed {
		kind_t               kind;
		logic [TIME_W-1:0]   now_time;
		logic                msg_is_hash_reply;
		logic [HASH_W-1:0]   msg_hash;
		logic                buffer_ok;
	} in_t;

	typedef struct packed {
		action_t             action;
		status_t             status;
		logic [RETRY_W-1:0]  retry_count;
	} out_t;

	typedef struct packed {
		logic [TIME_W-1:0]   timeout_ticks;
		logic [RETRY_W-1:0]  retry_limit;
		logic [HASH_W-1:0]   own_hash;
	} cfg_t;

endpackage
`default_nettype wire

### rtl/sih_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sih_cfg_regs: configuration register file
// APB-style slave holding timeout, retry limit and own hash; always ready.
// ----------------------------------------------------------------------------
module sih_cfg_regs (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire [sih_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire [sih_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [sih_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output sih_pkg::cfg_t                  cfg
);
	import sih_pkg::*;

	reg_idx_t idx;
	logic     wr_en;
	cfg_t     cfg_q;

	assign idx    = paddr[APB_ADDR_W-1:3];
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks <= TIMEOUT_RST;
			cfg_q.retry_limit   <= RETRY_RST;
			cfg_q.own_hash      <= OWN_HASH_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_TIMEOUT:  cfg_q.timeout_ticks <= pwdata[TIME_W-1:0];
				REG_RETRY:    cfg_q.retry_limit   <= pwdata[RETRY_W-1:0];
				REG_OWN_HASH: cfg_q.own_hash      <= pwdata[HASH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_TIMEOUT:  prdata = APB_DATA_W'(cfg_q.timeout_ticks);
			REG_RETRY:    prdata = APB_DATA_W'(cfg_q.retry_limit);
			REG_OWN_HASH: prdata = APB_DATA_W'(cfg_q.own_hash);
			default:      prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

### rtl/sih_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sih_core: handshake state and event processing
// Holds the protocol flags, retry counter and last send time, and computes
// the action and status for one event in a single pass.
// ----------------------------------------------------------------------------
module sih_core (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            update,
	input  sih_pkg::in_t   item,
	input  sih_pkg::cfg_t  cfg,
	output sih_pkg::out_t  result
);
	import sih_pkg::*;

	logic               sent_q, matched_q, failed_q;
	logic [RETRY_W-1:0] retries_q;
	logic [TIME_W-1:0]  last_send_q;

	logic               sent_d, matched_d, failed_d;
	logic [RETRY_W-1:0] retries_d;
	logic [TIME_W-1:0]  last_send_d;
	logic [TIME_W-1:0]  elapsed;
	logic               hash_hit;
	logic               timer_live;
	action_t            action;
	status_t            status;

	assign elapsed    = item.now_time - last_send_q;
	assign hash_hit   = item.msg_is_hash_reply & (item.msg_hash == cfg.own_hash);
	assign timer_live = sent_q & ~matched_q & ~failed_q & (elapsed >= cfg.timeout_ticks);

	always_comb begin
		sent_d      = sent_q;
		matched_d   = matched_q;
		failed_d    = failed_q;
		retries_d   = retries_q;
		last_send_d = last_send_q;
		action      = ACT_NONE;
		case (item.kind)
			KIND_START: begin
				if (item.buffer_ok) begin
					sent_d      = 1'b1;
					last_send_d = item.now_time;
					action      = ACT_DATA;
				end else begin
					failed_d = 1'b1;
				end
			end
			KIND_DGRAM: begin
				if (hash_hit) begin
					matched_d   = 1'b1;
					last_send_d = item.now_time;
					action      = item.buffer_ok ? ACT_FIN : ACT_NONE;
				end
			end
			KIND_TIMER: begin
				if (timer_live) begin
					if (retries_q >= cfg.retry_limit) begin
						failed_d = 1'b1;
					end else begin
						retries_d   = retries_q + RETRY_W'(1);
						last_send_d = item.now_time;
						action      = item.buffer_ok ? ACT_DATA : ACT_NONE;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (matched_d)
			status = ST_MATCHED;
		else if (failed_d)
			status = ST_FAILED;
		else if (sent_d)
			status = ST_WAITING;
		else
			status = ST_NOT_SENT;
	end

	assign result.action      = action;
	assign result.status      = status;
	assign result.retry_count = retries_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q      <= 1'b0;
			matched_q   <= 1'b0;
			failed_q    <= 1'b0;
			retries_q   <= '0;
			last_send_q <= '0;
		end else if (update) begin
			sent_q      <= sent_d;
			matched_q   <= matched_d;
			failed_q    <= failed_d;
			retries_q   <= retries_d;
			last_send_q <= last_send_d;
		end
	end

endmodule
`default_nettype wire

### rtl/setup_initiator_handshake.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// setup_initiator_handshake: initiator side of a setup handshake
// One event transaction in (start, received datagram or timer check), one
// result transaction out carrying the action to take, status and retry count.
//
// in_valid/in_stall carries events, out_valid/out_stall carries results; a
// transaction moves on an edge with valid high and stall low. An accepted
// event lands in an input register and is processed on the first edge at
// which the output register is empty or not stalled; there the state updates
// and the result is loaded into the output register. One event per cycle is
// sustained while the receiver does not stall, with the state update (64-bit
// elapsed-time subtract and compare) between the input and output registers.
// When the receiver stalls, the output register holds its result and one
// more event may wait in the input register; in_stall then rises.
// Reset clears all handshake state, empties both registers and loads the
// configuration registers with their defaults (timeout 1000000000, retry
// limit 5, own hash 0). The APB port is always ready; write configuration
// only while no transaction is in flight.
// ----------------------------------------------------------------------------
module setup_initiator_handshake (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  sih_pkg::in_t                   in_data,
	output logic                           out_valid,
	input  wire                            out_stall,
	output sih_pkg::out_t                  out_data,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire [sih_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire [sih_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [sih_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	import sih_pkg::*;

	cfg_t cfg;
	in_t  data_s1;
	logic valid_s1;
	out_t data_s2;
	logic valid_s2;
	out_t result;
	logic advance;
	logic accept;

	sih_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sih_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.update  (advance),
		.item    (data_s1),
		.cfg     (cfg),
		.result  (result)
	);

	assign advance   = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall  = valid_s1 & ~advance;
	assign accept    = in_valid & ~in_stall;
	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= result;
		end
	end

`ifndef ASSERT_OFF
	a_stall_only_when_full: assert property (
		@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2)
	) else $error("input stalled with a free stage");

	a_result_from_stage: assert property (
		@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1)
	) else $error("result appeared without a pending event");

	a_fin_means_matched: assert property (
		@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.action == ACT_FIN) |-> (out_data.status == ST_MATCHED)
	) else $error("final ack sent while not matched");

	a_data_means_sent: assert property (
		@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.action == ACT_DATA) |-> (out_data.status != ST_NOT_SENT)
	) else $error("data sent with status still not sent");
`endif

endmodule
`default_nettype wire
